// ----- hdl/button_click_classifier_unit_macros.svh -----
// Assertion macros used by the checker of the button click classifier.
`ifndef BUTTON_CLICK_CLASSIFIER_UNIT_MACROS_SVH
`define BUTTON_CLICK_CLASSIFIER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define BCC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define BCC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- hdl/bcc_pkg.sv -----
// Package with the types, widths and codes of the button click classifier.
package bcc_pkg;

  localparam int AGE_WIDTH  = 16;
  localparam int DEB_W      = 10;
  localparam int TICK_W     = 16;
  localparam int PERIOD_W   = 8;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CMP_W      = (AGE_WIDTH > TICK_W) ? AGE_WIDTH : TICK_W;

  localparam logic [AGE_WIDTH-1:0] AGE_MAX = '1;

  localparam logic [DEB_W-1:0]    DEB_RESET    = DEB_W'(50);
  localparam logic [TICK_W-1:0]   LONG_RESET   = TICK_W'(1000);
  localparam logic [TICK_W-1:0]   WINDOW_RESET = TICK_W'(400);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(20);

  typedef enum logic [1:0] {
    EV_SINGLE = 2'd0,
    EV_DOUBLE = 2'd1,
    EV_LONG   = 2'd2
  } ev_code_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_LONG     = 2'd1,
    CFG_WINDOW   = 2'd2,
    CFG_PERIOD   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [DEB_W-1:0]    debounce_ticks;
    logic [TICK_W-1:0]   long_press_ticks;
    logic [TICK_W-1:0]   double_window_ticks;
    logic [PERIOD_W-1:0] check_period_ticks;
  } bcc_cfg_t;

  typedef struct packed {
    logic     event_valid;
    ev_code_e event_code;
    logic     debounced_level;
  } bcc_result_t;

endpackage

// ----- hdl/bcc_cfg_regs.sv -----
// Configuration register bank of the button click classifier.
module bcc_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bcc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bcc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output bcc_pkg::bcc_cfg_t              cfg_o
);
  import bcc_pkg::*;

  bcc_cfg_t cfg_q;
  bcc_cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DEBOUNCE: cfg_d.debounce_ticks      = cfg_data_i[DEB_W-1:0];
        CFG_LONG:     cfg_d.long_press_ticks    = cfg_data_i[TICK_W-1:0];
        CFG_WINDOW:   cfg_d.double_window_ticks = cfg_data_i[TICK_W-1:0];
        CFG_PERIOD:   cfg_d.check_period_ticks  = cfg_data_i[PERIOD_W-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks      <= DEB_RESET;
      cfg_q.long_press_ticks    <= LONG_RESET;
      cfg_q.double_window_ticks <= WINDOW_RESET;
      cfg_q.check_period_ticks  <= PERIOD_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/bcc_core.sv -----
// Debounce, age counters, click counting and event classification for one tick.
module bcc_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic                  pin_level_i,
  input  bcc_pkg::bcc_cfg_t     cfg_i,
  output bcc_pkg::bcc_result_t  result_o
);
  import bcc_pkg::*;

  logic                 prior_q, prior_d;
  logic                 armed_q, armed_d;
  logic [DEB_W-1:0]     left_q, left_d;
  logic                 stable_q, stable_d;
  logic [AGE_WIDTH-1:0] press_q, press_d;
  logic [AGE_WIDTH-1:0] release_q, release_d;
  logic [1:0]           clicks_q, clicks_d;
  logic                 long_q, long_d;
  logic [PERIOD_W-1:0]  phase_q, phase_d;

  logic [AGE_WIDTH-1:0] press_inc;
  logic [AGE_WIDTH-1:0] release_inc;
  logic [PERIOD_W-1:0]  phase_inc;
  logic [PERIOD_W-1:0]  period;
  logic                 sample;
  logic                 ev_valid;
  ev_code_e             ev_code;

  assign press_inc   = (press_q == AGE_MAX) ? press_q : press_q + AGE_WIDTH'(1);
  assign release_inc = (release_q == AGE_MAX) ? release_q : release_q + AGE_WIDTH'(1);
  assign phase_inc   = phase_q + PERIOD_W'(1);
  assign period      = (cfg_i.check_period_ticks == '0) ? PERIOD_W'(1)
                                                        : cfg_i.check_period_ticks;

  always_comb begin
    prior_d   = pin_level_i;
    armed_d   = armed_q;
    left_d    = left_q;
    stable_d  = stable_q;
    press_d   = press_inc;
    release_d = release_inc;
    clicks_d  = clicks_q;
    long_d    = long_q;
    phase_d   = phase_inc;
    sample    = 1'b0;
    ev_valid  = 1'b0;
    ev_code   = EV_SINGLE;

    // A raw change restarts the countdown; otherwise an armed countdown runs out.
    if (pin_level_i != prior_q) begin
      armed_d = 1'b1;
      left_d  = (cfg_i.debounce_ticks == '0) ? DEB_W'(1) : cfg_i.debounce_ticks;
    end else if (armed_q) begin
      left_d = (left_q != '0) ? left_q - DEB_W'(1) : left_q;
      if (left_d == '0) begin
        armed_d = 1'b0;
        sample  = 1'b1;
      end
    end

    if (sample) begin
      if (pin_level_i && !stable_q) begin
        press_d = '0;
        long_d  = 1'b0;
      end
      if (!pin_level_i && stable_q && !long_q) begin
        release_d = '0;
        if (clicks_q != 2'd3) begin
          clicks_d = clicks_q + 2'd1;
        end
      end
      stable_d = pin_level_i;
    end

    if (phase_inc >= period || phase_inc == '0) begin
      phase_d = '0;
      if (stable_d && CMP_W'(press_d) > CMP_W'(cfg_i.long_press_ticks) && !long_d) begin
        long_d   = 1'b1;
        clicks_d = 2'd0;
        ev_valid = 1'b1;
        ev_code  = EV_LONG;
      end else if (clicks_d >= 2'd2) begin
        // A stale pair of clicks past the window is dropped without an event.
        clicks_d = 2'd0;
        if (CMP_W'(release_d) < CMP_W'(cfg_i.double_window_ticks)) begin
          ev_valid = 1'b1;
          ev_code  = EV_DOUBLE;
        end
      end else if (clicks_d == 2'd1 &&
                   CMP_W'(release_d) > CMP_W'(cfg_i.double_window_ticks)) begin
        clicks_d = 2'd0;
        ev_valid = 1'b1;
        ev_code  = EV_SINGLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_q   <= 1'b0;
      armed_q   <= 1'b0;
      left_q    <= '0;
      stable_q  <= 1'b0;
      press_q   <= '0;
      release_q <= '0;
      clicks_q  <= 2'd0;
      long_q    <= 1'b0;
      phase_q   <= '0;
    end else if (step_i) begin
      prior_q   <= prior_d;
      armed_q   <= armed_d;
      left_q    <= left_d;
      stable_q  <= stable_d;
      press_q   <= press_d;
      release_q <= release_d;
      clicks_q  <= clicks_d;
      long_q    <= long_d;
      phase_q   <= phase_d;
    end
  end

  assign result_o.event_valid     = ev_valid;
  assign result_o.event_code      = ev_code;
  assign result_o.debounced_level = stable_d;

endmodule

// ----- hdl/button_click_classifier_unit.sv -----
// Top level of the button click classifier: input stage, tick logic and result stage.
//
// Each input beat is one millisecond tick carrying the raw button level on
// pin_level_i; every input beat yields exactly one output beat with the event
// flag, the event code and the debounced level. Both channels use valid and
// ready. A beat is held in an input register, processed by the tick logic
// and written to the result register, which offers it as the output beat.
// One beat per cycle is sustained while the receiver is ready: the input
// register refills in the same cycle its beat moves on, and the only path
// that limits the rate is the per-tick update of the state registers.
// When the receiver stalls, the result register holds its beat and the
// input register keeps one more; in_ready_o falls only while both are full.
// Reset clears both stages, the debounce, age, click and phase state, and
// loads the default configuration. The configuration port writes one
// register per cycle with cfg_we_i and should be used only while idle.
module button_click_classifier_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           pin_level_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           event_valid_o,
  output logic [1:0]                     event_code_o,
  output logic                           debounced_level_o,
  input  logic                           cfg_we_i,
  input  logic [bcc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bcc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bcc_pkg::*;

  bcc_cfg_t    cfg;
  bcc_result_t step_result;
  bcc_result_t result_q;
  logic        in_valid_q;
  logic        pin_q;
  logic        out_valid_q;
  logic        advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  bcc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bcc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .pin_level_i (pin_q),
    .cfg_i       (cfg),
    .result_o    (step_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      pin_q <= pin_level_i;
    end
    if (advance) begin
      result_q <= step_result;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign event_valid_o     = result_q.event_valid;
  assign event_code_o      = result_q.event_code;
  assign debounced_level_o = result_q.debounced_level;

endmodule

// ----- hdl/bcc_checker.sv -----
// Port-level checker of the button click classifier and its bind statement.
`include "button_click_classifier_unit_macros.svh"

module bcc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic                           event_valid_o,
  input logic [1:0]                     event_code_o,
  input logic                           debounced_level_o
);
  import bcc_pkg::*;

  // A stalled output beat keeps its payload.
  `BCC_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(event_valid_o) && $stable(event_code_o) && $stable(debounced_level_o))

  // Without an event the code reads as zero.
  `BCC_ASSERT_IMP(a_code_idle, out_valid_o && !event_valid_o, event_code_o == EV_SINGLE)

  // A long press is only reported while the button is held.
  `BCC_ASSERT_IMP(a_long_held, out_valid_o && event_valid_o && event_code_o == EV_LONG,
    debounced_level_o)

  // The input side only backs up when the result stage is full and stalled.
  `BCC_ASSERT_IMP(a_stall_cause, !in_ready_o, out_valid_o && !out_ready_i)

endmodule

bind button_click_classifier_unit bcc_checker u_bcc_checker (.*);
